>>> src/i2bt_pkg.sv
// ----------------------------------------------------------------------------
// i2bt_pkg
// shared types and constants of the binary to balanced ternary converter
// ----------------------------------------------------------------------------
package i2bt_pkg;

    localparam int DATA_W        = 64;
    localparam int TRIT_W        = 2;
    localparam int MAX_TRITS_DEF = 41;
    localparam int QUEUE_DEPTH   = 2;

    // trit encoding: +1 is 01, 0 is 00, -1 is 11
    localparam logic [TRIT_W-1:0] TRIT_ZERO = 2'b00;
    localparam logic [TRIT_W-1:0] TRIT_POS  = 2'b01;
    localparam logic [TRIT_W-1:0] TRIT_NEG  = 2'b11;

    typedef struct packed {
        logic              neg;
        logic [DATA_W-1:0] mag;
    } i2bt_item_t;

endpackage

>>> src/i2bt_front.sv
// ----------------------------------------------------------------------------
// i2bt_front
// accepts input transactions, splits sign and magnitude, queues them
// ----------------------------------------------------------------------------
module i2bt_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [i2bt_pkg::DATA_W-1:0] value,
    output logic                             item_valid,
    input  logic                             item_ready,
    output i2bt_pkg::i2bt_item_t             item
);
    import i2bt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    i2bt_item_t        queue_mem [QUEUE_DEPTH];
    i2bt_item_t        classified;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic              push;
    logic              pop;

    // magnitude as unsigned, so the most negative value gives 2^63
    always_comb
    begin
        classified.neg = value[DATA_W-1];
        classified.mag = value[DATA_W-1] ? (~value + DATA_W'(1)) : value;
    end

    assign in_ready   = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign item_valid = (fill_reg != '0);
    assign item       = queue_mem[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

>>> src/i2bt_back.sv
// ----------------------------------------------------------------------------
// i2bt_back
// repeated division by 3 into a digit memory, then readout msb first
// ----------------------------------------------------------------------------
module i2bt_back
#(
    parameter int MAX_TRITS = i2bt_pkg::MAX_TRITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  i2bt_pkg::i2bt_item_t              item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [i2bt_pkg::TRIT_W-1:0] trit,
    output logic                              last
);
    import i2bt_pkg::*;

    localparam int IDX_W   = $clog2(MAX_TRITS);
    localparam int CHUNK_W = 8;
    localparam int CHUNKS  = DATA_W / CHUNK_W;
    localparam int CHK_W   = $clog2(CHUNKS);
    localparam int REM_W   = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_NEXT,
        ST_EMIT
    } state_t;

    // long division of one byte by 3, remainder carried in from above
    function automatic logic [REM_W+CHUNK_W-1:0] div_chunk(
        input logic [REM_W-1:0]   rem_in,
        input logic [CHUNK_W-1:0] dividend
    );
        logic [REM_W:0]       r;
        logic [CHUNK_W-1:0]   q;
        r = {1'b0, rem_in};
        q = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            r = {r[REM_W-1:0], dividend[i]};
            if (r >= 3'd3)
            begin
                r    = r - 3'd3;
                q[i] = 1'b1;
            end
        end
        return {r[REM_W-1:0], q};
    endfunction

    logic [TRIT_W-1:0] digit_mem [MAX_TRITS];

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] mag_reg, mag_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              neg_reg, neg_next;
    logic [CHK_W-1:0]  chunk_reg, chunk_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  emit_idx_reg, emit_idx_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_last_reg, rd_last_next;
    logic [TRIT_W-1:0] rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic [TRIT_W-1:0] out_trit_reg, out_trit_next;
    logic              out_last_reg, out_last_next;

    logic [REM_W+CHUNK_W-1:0] div_res;
    logic                     carry;
    logic [TRIT_W-1:0]        digit;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [TRIT_W-1:0]        wr_data;
    logic                     issue;
    logic                     load_out;
    logic                     slot_free;

    assign item_ready = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign trit       = out_trit_reg;
    assign last       = out_last_reg;

    assign div_res  = div_chunk(rem_reg, mag_reg[DATA_W-1 -: CHUNK_W]);
    assign carry    = (rem_reg == 2'd2);

    // remainder 2 becomes -1 with a carry; sign flips for negative input
    always_comb
    begin
        case (rem_reg)
            2'd1:    digit = neg_reg ? TRIT_NEG : TRIT_POS;
            2'd2:    digit = neg_reg ? TRIT_POS : TRIT_NEG;
            default: digit = TRIT_ZERO;
        endcase
    end

    assign load_out  = rd_valid_reg && (!out_valid_reg || out_ready);
    assign slot_free = !rd_valid_reg || load_out;

    always_comb
    begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        chunk_next    = chunk_reg;
        cnt_next      = cnt_reg;
        emit_idx_next = emit_idx_reg;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg;
        wr_data       = TRIT_ZERO;
        issue         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    neg_next   = item.neg;
                    mag_next   = item.mag;
                    rem_next   = '0;
                    chunk_next = '0;
                    cnt_next   = '0;
                    if (item.mag == '0)
                    begin
                        // zero input gives a single 0 trit
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        emit_idx_next = '0;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                // quotient bytes shift in at the bottom as dividend bytes leave the top
                mag_next   = {mag_reg[DATA_W-CHUNK_W-1:0], div_res[CHUNK_W-1:0]};
                rem_next   = div_res[REM_W+CHUNK_W-1:CHUNK_W];
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == CHK_W'(CHUNKS - 1))
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                wr_en      = 1'b1;
                wr_data    = digit;
                mag_next   = mag_reg + DATA_W'(carry);
                rem_next   = '0;
                chunk_next = '0;
                if (((mag_reg == '0) && !carry) || (cnt_reg == IDX_W'(MAX_TRITS - 1)))
                begin
                    emit_idx_next = cnt_reg;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    issue = 1'b1;
                    if (emit_idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_valid_next = issue || (rd_valid_reg && !load_out);
        rd_last_next  = issue ? (emit_idx_reg == '0) : rd_last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_trit_next  = rd_data_reg;
            out_last_next  = rd_last_reg;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
            out_trit_next  = out_trit_reg;
            out_last_next  = out_last_reg;
        end
    end

    // digit memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            digit_mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= digit_mem[emit_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mag_reg       <= '0;
            rem_reg       <= '0;
            neg_reg       <= 1'b0;
            chunk_reg     <= '0;
            cnt_reg       <= '0;
            emit_idx_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_trit_reg  <= TRIT_ZERO;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mag_reg       <= mag_next;
            rem_reg       <= rem_next;
            neg_reg       <= neg_next;
            chunk_reg     <= chunk_next;
            cnt_reg       <= cnt_next;
            emit_idx_reg  <= emit_idx_next;
            rd_valid_reg  <= rd_valid_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
            out_trit_reg  <= out_trit_next;
            out_last_reg  <= out_last_next;
        end
    end

endmodule

>>> src/int_to_balanced_ternary.sv
// ----------------------------------------------------------------------------
// int_to_balanced_ternary
// converts a signed 64-bit integer to balanced ternary trits, msb first
//
//   channel  signals                      width  per transaction
//   input    in_valid, in_ready, value    64     one signed integer
//   output   out_valid, out_ready, trit,  2, 1   one trit, last on the lsb trit
//            last
//
// each trit is generated by byte-wise division by 3 in one shared divider
// step, followed by the digit write and carry; a zero input skips division.
// trits then leave one per cycle from the digit memory while out_ready holds.
// a two-entry queue keeps accepting inputs while the back end works.
// reset is asynchronous, active low; out_ready low stalls the readout only.
// ----------------------------------------------------------------------------
module int_to_balanced_ternary
#(
    parameter int MAX_TRITS = i2bt_pkg::MAX_TRITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [i2bt_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [i2bt_pkg::TRIT_W-1:0] trit,
    output logic                              last
);
    import i2bt_pkg::*;

    i2bt_item_t item;
    logic       item_valid;
    logic       item_ready;

    i2bt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    i2bt_back
    #(
        .MAX_TRITS (MAX_TRITS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .trit       (trit),
        .last       (last)
    );

endmodule

>>> tb/sv/int_to_balanced_ternary_tb.sv
// ----------------------------------------------------------------------------
// int_to_balanced_ternary_tb
// self-checking bench for the binary to balanced ternary converter
//
// each accepted integer is converted here by repeated division by 3. The
// expected trits, msb first with last on the lsb trit, are queued. Every
// output transaction is then checked against that queue. Directed corner
// values come first, then random values in three phases, the first two
// with random gaps on both channels. One long output stall fills the block.
// ----------------------------------------------------------------------------
module int_to_balanced_ternary_tb;

    import i2bt_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 400;
    localparam int LONG_HOLD     = 2500;
    localparam int PHASE_ITEMS   = 67;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [TRIT_W-1:0] trit;
        logic              last;
    } trit_result_t;

    class ternary_scoreboard;
        trit_result_t trit_q[$];
        int           errors;
        int           seen;

        function void report_error(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("mismatch at trit %0d: %s", seen, msg);
        endfunction

        // balanced ternary digits of one input, queued msb first
        function void note_input(logic signed [DATA_W-1:0] v);
            logic              neg;
            logic [DATA_W-1:0] mag;
            logic [DATA_W-1:0] rem;
            logic [TRIT_W-1:0] digits[$];
            trit_result_t      res;
            neg = v[DATA_W-1];
            mag = v;
            if (neg)
                mag = ~mag + 64'd1;
            if (mag == 64'd0)
                digits.push_back(TRIT_ZERO);
            while (mag != 64'd0 && digits.size() < MAX_TRITS_DEF)
            begin
                rem = mag % 64'd3;
                mag = mag / 64'd3;
                if (rem == 64'd0)
                    digits.push_back(TRIT_ZERO);
                else if (rem == 64'd1)
                    digits.push_back(neg ? TRIT_NEG : TRIT_POS);
                else
                begin
                    // remainder 2 is -1 with a carry upward
                    digits.push_back(neg ? TRIT_POS : TRIT_NEG);
                    mag = mag + 64'd1;
                end
            end
            for (int k = digits.size() - 1; k >= 0; k--)
            begin
                res.trit = digits[k];
                res.last = (k == 0);
                trit_q.push_back(res);
            end
        endfunction

        function void check_result(logic [TRIT_W-1:0] got_trit, logic got_last);
            trit_result_t want;
            if (trit_q.size() == 0)
            begin
                report_error($sformatf("unexpected trit %b last %b", got_trit, got_last));
                seen++;
                return;
            end
            want = trit_q.pop_front();
            if (got_trit !== want.trit)
                report_error($sformatf("trit expected %b got %b", want.trit, got_trit));
            if (got_last !== want.last)
                report_error($sformatf("last expected %b got %b", want.last, got_last));
            seen++;
        endfunction

        function int outstanding();
            return trit_q.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [DATA_W-1:0]  value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [TRIT_W-1:0]  trit;
    logic                      last;

    ternary_scoreboard trit_sb;
    int                sender_idle_pct;
    int                receiver_idle_pct;
    int                hold_request;
    int                hold_left;
    int                cycle_count;

    int_to_balanced_ternary dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .trit      (trit),
        .last      (last)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("int_to_balanced_ternary verification failed");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
            out_ready = rst_n && ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            trit_sb.check_result(trit, last);
    end

    // starts and ends at a falling edge
    task automatic send_value(input logic signed [DATA_W-1:0] v);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        value = v;
        do
            @(posedge clk);
        while (!in_ready);
        trit_sb.note_input(v);
        @(negedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] random_value();
        logic [DATA_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2: ;
            3, 4, 5, 6: r = r >> $urandom_range(DATA_W - 1);
            7:       r = 64'($urandom_range(1000));
            default:
            begin
                // near the signed extremes
                if ($urandom_range(1))
                    r = {1'b1, 63'd0} + 64'($urandom_range(3));
                else
                    r = {1'b0, {63{1'b1}}} - 64'($urandom_range(3));
                return r;
            end
        endcase
        if ($urandom_range(1))
            r = ~r + 64'd1;
        return r;
    endfunction

    task automatic run_random(input int n, input int snd_pct, input int rcv_pct);
        sender_idle_pct = snd_pct;
        receiver_idle_pct = rcv_pct;
        for (int i = 0; i < n; i++)
            send_value(random_value());
    endtask

    task automatic wait_all_trits();
        in_valid = 1'b0;
        while (trit_sb.outstanding() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic signed [DATA_W-1:0] corner_values[$];
        trit_sb = new;
        sender_idle_pct = 21;
        receiver_idle_pct = 54;
        hold_request = 0;
        hold_left = 0;
        cycle_count = 0;
        corner_values = '{
            64'sd0, 64'sd1, -64'sd1, 64'sd2, -64'sd2, 64'sd3, -64'sd3,
            64'sd13, -64'sd13, 64'sd40, -64'sd40,
            64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000,
            64'sh8000_0000_0000_0001, 64'sh7FFF_FFFF_FFFF_FFFE,
            // largest magnitude that still fits in 40 trits, and one past it
            64'sd6078832729528464400, 64'sd6078832729528464401,
            -64'sd6078832729528464401,
            64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA
        };

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (corner_values[i])
            send_value(corner_values[i]);

        run_random(30, 21, 54);
        // long output stall while inputs keep coming
        hold_request = LONG_HOLD;
        run_random(PHASE_ITEMS - 30, 21, 54);

        wait_all_trits();
        run_random(PHASE_ITEMS, 54, 21);
        run_random(PHASE_ITEMS, 0, 0);

        wait_all_trits();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (trit_sb.errors == 0 && trit_sb.outstanding() == 0)
            $display("int_to_balanced_ternary verification clean");
        else
            $display("int_to_balanced_ternary verification failed");
        $finish;
    end

endmodule

>>> int_to_balanced_ternary.f
src/i2bt_pkg.sv
src/i2bt_front.sv
src/i2bt_back.sv
src/int_to_balanced_ternary.sv
tb/sv/int_to_balanced_ternary_tb.sv
